/* src/dfa_scan_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DFA scanner package
// Shared widths, command and cause codes, register indexes and the structs
// passed between the scanner top level and its alphabet matcher and store.
// ----------------------------------------------------------------------------
package dfa_scan_pkg;

    localparam int CHAR_W       = 8;
    localparam int STATE_W      = 4;
    localparam int SYM_W        = 3;
    localparam int NEXT_W       = 5;
    localparam int LEN_W        = 12;
    localparam int CAUSE_W      = 2;
    localparam int CMD_W        = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int ALPHA_SIZE_W = 4;
    localparam int MASK_W       = 16;

    localparam int DEF_STATE_COUNT = 16;
    localparam int DEF_NUM_SYMBOLS = 8;
    localparam int DEF_MAX_LENGTH  = 4095;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_CHAR  = 2'd2,
        CMD_END   = 2'd3
    } cmd_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_UNKNOWN  = 2'd0,
        CAUSE_NO_TRANS = 2'd1,
        CAUSE_END      = 2'd2
    } cause_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd3;

    typedef struct packed {
        logic               en;
        logic [STATE_W-1:0] row;
        logic [SYM_W-1:0]   col;
        logic               ok;
        logic [STATE_W-1:0] next;
    } store_wr_t;

    typedef struct packed {
        logic               ok;
        logic [STATE_W-1:0] next;
    } store_rsp_t;

    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] index;
    } sym_match_t;

endpackage

/* src/table_driven_dfa_scanner_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table-driven DFA scanner
// Programmable automaton: loads transition entries, starts scans, steps one
// character per transaction and reports one result when a scan stops.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------
//   input    | in_valid / in_stall     | command, char_byte, entry_state,
//            |                         | entry_symbol, entry_next
//   result   | out_valid / out_stall   | accepted, lexeme_length, stop_cause
//   config   | cfg_we                  | cfg_index, cfg_data
//
// One transaction per cycle while in_stall is low; the input register feeds the result register.
// The next-state memory is read at the upcoming state and registered along with it.
// Reset clears the transition flags at once; no clearing pass is needed.
// in_stall rises only while an input is held and the result register is stalled.
// ----------------------------------------------------------------------------
module table_driven_dfa_scanner_unit #(
    parameter int STATE_COUNT = dfa_scan_pkg::DEF_STATE_COUNT,
    parameter int NUM_SYMBOLS = dfa_scan_pkg::DEF_NUM_SYMBOLS,
    parameter int MAX_LENGTH  = dfa_scan_pkg::DEF_MAX_LENGTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [dfa_scan_pkg::CMD_W-1:0]        command,
    input  logic [dfa_scan_pkg::CHAR_W-1:0]       char_byte,
    input  logic [dfa_scan_pkg::STATE_W-1:0]      entry_state,
    input  logic [dfa_scan_pkg::SYM_W-1:0]        entry_symbol,
    input  logic signed [dfa_scan_pkg::NEXT_W-1:0] entry_next,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  accepted,
    output logic [dfa_scan_pkg::LEN_W-1:0]        lexeme_length,
    output logic [dfa_scan_pkg::CAUSE_W-1:0]      stop_cause,

    input  logic                                  cfg_we,
    input  logic [dfa_scan_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfa_scan_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int StateW  = dfa_scan_pkg::STATE_W;
    localparam int StateLW = StateW + 1;
    localparam int SymW    = dfa_scan_pkg::SYM_W;
    localparam int SymLW   = SymW + 1;
    localparam int CharW   = dfa_scan_pkg::CHAR_W;
    localparam int NextW   = dfa_scan_pkg::NEXT_W;
    localparam int LenW    = dfa_scan_pkg::LEN_W;
    localparam int CauseW  = dfa_scan_pkg::CAUSE_W;
    localparam int DataW   = dfa_scan_pkg::CFG_DATA_W;
    localparam int SizeW   = dfa_scan_pkg::ALPHA_SIZE_W;
    localparam int MaskW   = dfa_scan_pkg::MASK_W;
    localparam int Rows    = (STATE_COUNT < (1 << StateW)) ? STATE_COUNT : (1 << StateW);
    localparam int CntW    = $clog2(MAX_LENGTH + 1);
    localparam logic [StateLW-1:0] RowLimit = StateLW'(Rows);
    localparam logic [SymLW-1:0]   SymLimit = SymLW'(NUM_SYMBOLS);
    localparam logic [CntW-1:0]    MaxCnt   = CntW'(MAX_LENGTH);

    // configuration
    logic [DataW-1:0]  alphabet_reg;
    logic [SizeW-1:0]  alpha_size_reg;
    logic [MaskW-1:0]  accept_mask_reg;
    logic [StateW-1:0] start_state_reg;

    // input register
    logic                    in_v_reg;
    dfa_scan_pkg::cmd_t      cmd_reg;
    logic [CharW-1:0]        char_reg;
    logic [StateW-1:0]       estate_reg;
    logic [SymW-1:0]         esym_reg;
    logic [NextW-1:0]        enext_reg;

    // scan state
    logic [StateW-1:0] cur_reg;
    logic [StateW-1:0] cur_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              scan_reg;
    logic              scan_next;

    // result register
    logic                 out_v_reg;
    logic                 accepted_reg;
    logic [LenW-1:0]      len_reg;
    logic [CauseW-1:0]    cause_reg;

    logic                     out_ready;
    logic                     fire;
    logic                     in_take;
    logic                     res_v;
    dfa_scan_pkg::cause_t     res_cause;
    logic                     res_accepted;
    logic                     load_ok;
    logic                     next_ok;
    dfa_scan_pkg::store_wr_t  wr;
    dfa_scan_pkg::store_rsp_t rsp;
    dfa_scan_pkg::sym_match_t sym;

    assign out_ready = !out_v_reg || !out_stall;
    assign fire      = in_v_reg && out_ready;
    assign in_stall  = in_v_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_reg    <= '0;
            alpha_size_reg  <= '0;
            accept_mask_reg <= '0;
            start_state_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dfa_scan_pkg::CFG_ALPHABET:    alphabet_reg    <= cfg_data;
                dfa_scan_pkg::CFG_ALPHA_SIZE:  alpha_size_reg  <= cfg_data[SizeW-1:0];
                dfa_scan_pkg::CFG_ACCEPT_MASK: accept_mask_reg <= cfg_data[MaskW-1:0];
                dfa_scan_pkg::CFG_START_STATE: start_state_reg <= cfg_data[StateW-1:0];
                default:                       alphabet_reg    <= alphabet_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_v_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg    <= dfa_scan_pkg::cmd_t'(command);
            char_reg   <= char_byte;
            estate_reg <= entry_state;
            esym_reg   <= entry_symbol;
            enext_reg  <= entry_next;
        end
    end

    dfa_scan_symmap #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_symmap (
        .char_in    (char_reg),
        .alphabet   (alphabet_reg),
        .alpha_size (alpha_size_reg),
        .match      (sym)
    );

    dfa_scan_store #(
        .STATE_COUNT (STATE_COUNT),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .rd_state   (cur_next),
        .look_state (cur_reg),
        .look_sym   (sym.index),
        .rsp        (rsp)
    );

    assign load_ok = ({1'b0, estate_reg} < RowLimit) && ({1'b0, esym_reg} < SymLimit);
    assign next_ok = !enext_reg[NextW-1] && ({1'b0, enext_reg[StateW-1:0]} < RowLimit);
    assign res_accepted = accept_mask_reg[cur_reg] && (count_reg != '0);

    always_comb
    begin
        cur_next   = cur_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        res_v      = 1'b0;
        res_cause  = dfa_scan_pkg::CAUSE_END;
        wr.en      = 1'b0;
        wr.row     = estate_reg;
        wr.col     = esym_reg;
        wr.ok      = next_ok;
        wr.next    = enext_reg[StateW-1:0];
        unique case (cmd_reg)
            dfa_scan_pkg::CMD_LOAD:
            begin
                wr.en = fire && load_ok;
            end
            dfa_scan_pkg::CMD_START:
            begin
                if (fire)
                begin
                    cur_next   = start_state_reg;
                    count_next = '0;
                    scan_next  = 1'b1;
                end
            end
            dfa_scan_pkg::CMD_CHAR:
            begin
                if (fire && scan_reg)
                begin
                    if (!sym.hit)
                    begin
                        res_v     = 1'b1;
                        res_cause = dfa_scan_pkg::CAUSE_UNKNOWN;
                        scan_next = 1'b0;
                    end
                    else if (!rsp.ok)
                    begin
                        res_v     = 1'b1;
                        res_cause = dfa_scan_pkg::CAUSE_NO_TRANS;
                        scan_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = rsp.next;
                        if (count_reg < MaxCnt)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            dfa_scan_pkg::CMD_END:
            begin
                if (fire && scan_reg)
                begin
                    res_v     = 1'b1;
                    res_cause = dfa_scan_pkg::CAUSE_END;
                    scan_next = 1'b0;
                end
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            count_reg <= '0;
            scan_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            cur_reg   <= cur_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            if (res_v)
            begin
                out_v_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_v)
        begin
            accepted_reg <= res_accepted;
            len_reg      <= LenW'(count_reg);
            cause_reg    <= res_cause;
        end
    end

    assign out_valid     = out_v_reg;
    assign accepted      = accepted_reg;
    assign lexeme_length = len_reg;
    assign stop_cause    = cause_reg;

endmodule

/* src/dfa_scan_symmap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DFA scanner alphabet matcher
// Compares one byte against all configured alphabet symbols in parallel and
// returns the lowest matching symbol index.
// ----------------------------------------------------------------------------
module dfa_scan_symmap #(
    parameter int NUM_SYMBOLS = dfa_scan_pkg::DEF_NUM_SYMBOLS
) (
    input  logic [dfa_scan_pkg::CHAR_W-1:0]       char_in,
    input  logic [dfa_scan_pkg::CFG_DATA_W-1:0]   alphabet,
    input  logic [dfa_scan_pkg::ALPHA_SIZE_W-1:0] alpha_size,
    output dfa_scan_pkg::sym_match_t              match
);

    localparam int CharW = dfa_scan_pkg::CHAR_W;
    localparam int SizeW = dfa_scan_pkg::ALPHA_SIZE_W;
    localparam int SymW  = dfa_scan_pkg::SYM_W;
    localparam logic [SizeW-1:0] SymLimit = SizeW'(NUM_SYMBOLS);

    logic [SizeW-1:0]       used;
    logic [NUM_SYMBOLS-1:0] hits;

    assign used = (alpha_size > SymLimit) ? SymLimit : alpha_size;

    always_comb
    begin
        for (int k = 0; k < NUM_SYMBOLS; k++)
        begin
            hits[k] = (SizeW'(k) < used) && (alphabet[CharW*k +: CharW] == char_in);
        end
    end

    always_comb
    begin
        match.hit   = 1'b0;
        match.index = '0;
        for (int k = NUM_SYMBOLS - 1; k >= 0; k--)
        begin
            if (hits[k])
            begin
                match.hit   = 1'b1;
                match.index = SymW'(k);
            end
        end
    end

endmodule

/* src/dfa_scan_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DFA scanner transition store
// Row-wide memory of next states, read ahead at the upcoming state and registered,
// per-entry transition flags cleared by reset, and a bypass for a write that
// lands on the row being read in the same cycle.
// ----------------------------------------------------------------------------
module dfa_scan_store #(
    parameter int STATE_COUNT = dfa_scan_pkg::DEF_STATE_COUNT,
    parameter int NUM_SYMBOLS = dfa_scan_pkg::DEF_NUM_SYMBOLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dfa_scan_pkg::store_wr_t           wr,
    input  logic [dfa_scan_pkg::STATE_W-1:0]  rd_state,
    input  logic [dfa_scan_pkg::STATE_W-1:0]  look_state,
    input  logic [dfa_scan_pkg::SYM_W-1:0]    look_sym,
    output dfa_scan_pkg::store_rsp_t          rsp
);

    localparam int StateW  = dfa_scan_pkg::STATE_W;
    localparam int StateLW = StateW + 1;
    localparam int Rows    = (STATE_COUNT < (1 << StateW)) ? STATE_COUNT : (1 << StateW);
    localparam int RowW    = $clog2(Rows);
    localparam int ColW    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam logic [StateLW-1:0] RowLimit = StateLW'(Rows);

    logic [RowW-1:0]        mem [Rows][NUM_SYMBOLS];
    logic [RowW-1:0]        row_reg [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] ok_reg [Rows];
    logic                   fwd_hit_reg;
    logic                   fwd_hit_next;
    logic [ColW-1:0]        fwd_col_reg;
    logic [RowW-1:0]        fwd_data_reg;

    logic [RowW-1:0] wr_row;
    logic [ColW-1:0] wr_col;
    logic [RowW-1:0] rd_row;
    logic [RowW-1:0] look_row;
    logic [ColW-1:0] look_col;
    logic            look_in;
    logic [RowW-1:0] look_data;

    assign wr_row   = wr.row[RowW-1:0];
    assign wr_col   = wr.col[ColW-1:0];
    assign rd_row   = ({1'b0, rd_state} < RowLimit) ? rd_state[RowW-1:0] : '0;
    assign look_in  = ({1'b0, look_state} < RowLimit);
    assign look_row = look_in ? look_state[RowW-1:0] : '0;
    assign look_col = look_sym[ColW-1:0];

    assign fwd_hit_next = wr.en && wr.ok && (wr.row == rd_state);

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.ok)
        begin
            mem[wr_row][wr_col] <= wr.next[RowW-1:0];
        end
        row_reg      <= mem[rd_row];
        fwd_col_reg  <= wr_col;
        fwd_data_reg <= wr.next[RowW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < Rows; r++)
            begin
                ok_reg[r] <= '0;
            end
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                ok_reg[wr_row][wr_col] <= wr.ok;
            end
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    assign look_data = (fwd_hit_reg && (fwd_col_reg == look_col)) ? fwd_data_reg
                                                                  : row_reg[look_col];

    assign rsp.ok   = look_in && ok_reg[look_row][look_col];
    assign rsp.next = StateW'(look_data);

endmodule

/* src/dfa_scan_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DFA scanner port checker
// Watches the scanner ports for result ordering, stall and reset behavior.
// ----------------------------------------------------------------------------
module dfa_scan_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic                                   accepted,
    input logic [dfa_scan_pkg::LEN_W-1:0]         lexeme_length,
    input logic [dfa_scan_pkg::CAUSE_W-1:0]       stop_cause
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({accepted, lexeme_length, stop_cause}))
        else $error("stalled result changed or dropped");

    // stall input only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // a new result follows an earlier accepted transaction
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching transaction");

    // drop results during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind table_driven_dfa_scanner_unit dfa_scan_checker u_dfa_scan_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .lexeme_length (lexeme_length),
    .stop_cause    (stop_cause)
);
